// ===== rtl/multi_sample_frame_deframer_core_assert.svh =====
// Assertion macros used by the checker file of the frame deframer.
// Depends on nothing; the including file supplies clock, reset and property.
`ifndef MULTI_SAMPLE_FRAME_DEFRAMER_CORE_ASSERT_SVH
`define MULTI_SAMPLE_FRAME_DEFRAMER_CORE_ASSERT_SVH

// Checked at every rising edge outside reset.
`define MSFD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Checked at every rising edge, reset included.
`define MSFD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/msfd_pkg.sv =====
// Package of the frame deframer: types, codes and constants.
// Used by the interfaces, every RTL module and the checker; depends on nothing.
package msfd_pkg;

  localparam int unsigned FIFO_DEPTH  = 2;
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned APB_DATA_W  = 32;

  // Register index, taken from the byte address above the word offset.
  localparam logic REG_EXPECT_HDR = 1'b0;

  localparam logic [9:0] ID_TRAILER  = 10'h3ff;
  localparam logic [4:0] IDX_TRAILER = 5'h1f;
  localparam logic [7:0] COUNT_MAX   = 8'hff;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_RO_HDR  = 3'd1,
    PH_RSV     = 3'd2,
    PH_TS_LO   = 3'd3,
    PH_TS_HI   = 3'd4,
    PH_SHDR    = 3'd5,
    PH_PAYLOAD = 3'd6,
    PH_DONE    = 3'd7
  } phase_e;

  typedef enum logic [2:0] {
    KIND_RO_HDR  = 3'd0,
    KIND_RSV     = 3'd1,
    KIND_TS_LO   = 3'd2,
    KIND_TS_HI   = 3'd3,
    KIND_SHDR    = 3'd4,
    KIND_PAYLOAD = 3'd5,
    KIND_IGNORE  = 3'd6
  } kind_e;

  // One classified word, as the front hands it to the back.
  typedef struct packed {
    logic [31:0] word;
    logic        start;
    kind_e       kind;
    logic        last;
  } entry_t;

  typedef struct packed {
    kind_e       word_kind;
    logic [31:0] word_out;
    logic [7:0]  sample_index;
    logic [9:0]  link_id;
    logic        interest_flag;
    logic [7:0]  interest_index;
    logic        id_mismatch;
    logic        index_mismatch;
    logic        last_of_sample;
    logic [7:0]  contributor;
    logic [7:0]  subsystem;
    logic [63:0] stamp;
  } result_t;

endpackage

// ===== rtl/msfd_if.sv =====
// Stream interfaces of the frame deframer: input words and result beats.
// Depends on msfd_pkg.
interface msfd_in_if;
  import msfd_pkg::*;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic        frame_start;

  modport source (output valid, data_word, frame_start, input ready);
  modport sink   (input valid, data_word, frame_start, output ready);
endinterface

interface msfd_out_if;
  import msfd_pkg::*;
  logic        valid;
  logic        ready;
  logic [2:0]  word_kind;
  logic [31:0] word_out;
  logic [7:0]  sample_index;
  logic [9:0]  link_id;
  logic        interest_flag;
  logic [7:0]  interest_index;
  logic        id_mismatch;
  logic        index_mismatch;
  logic        last_of_sample;
  logic [7:0]  contributor;
  logic [7:0]  subsystem;
  logic [63:0] stamp;

  modport source (output valid, word_kind, word_out, sample_index, link_id, interest_flag,
                  interest_index, id_mismatch, index_mismatch, last_of_sample,
                  contributor, subsystem, stamp, input ready);
  modport sink   (input valid, word_kind, word_out, sample_index, link_id, interest_flag,
                  interest_index, id_mismatch, index_mismatch, last_of_sample,
                  contributor, subsystem, stamp, output ready);
endinterface

// ===== rtl/multi_sample_frame_deframer_core.sv =====
// Top level of the multi-sample frame deframer: front, queue, back, APB register.
// Depends on msfd_pkg, msfd_if, msfd_front, msfd_fifo and msfd_back.
//
//   Channel   Direction  Handshake            Carries
//   in_i      in         valid / ready        data_word, frame_start
//   out_o     out        valid / ready        one classified result per input word
//   APB       in / out   psel, penable, ...   expect_readout_header at byte address 0
//
// Throughput is one word per clock while out_o is not stalled; the front phase register
// and the back counter registers each update once per word. An accepted input beat
// is written into the queue, then popped into the result register that drives out_o.
// Reset is asynchronous and active low; it empties the queue and the result register.
// A stalled output fills the queue first and only then drops in_i.ready.
module multi_sample_frame_deframer_core #(
  parameter int unsigned FifoDepth = msfd_pkg::FIFO_DEPTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  msfd_in_if.sink                            in_i,
  msfd_out_if.source                         out_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [msfd_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [msfd_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [msfd_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready
);
  import msfd_pkg::*;

  logic   expect_hdr_q;
  logic   reg_sel;
  logic   cfg_write;

  logic   push_valid, push_ready;
  entry_t push_data;
  logic   pop_valid, pop_ready;
  entry_t pop_data;

  // Single register; the word offset bits of the address are not decoded.
  assign pready    = 1'b1;
  assign reg_sel   = (paddr[APB_ADDR_W-1:2] == REG_EXPECT_HDR);
  assign cfg_write = psel && penable && pwrite && pready && reg_sel;
  assign prdata    = reg_sel ? {{(APB_DATA_W-1){1'b0}}, expect_hdr_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_hdr_q <= 1'b0;
    end else if (cfg_write) begin
      expect_hdr_q <= pwdata[0];
    end
  end

  // The front only knows the parse phase and the payload countdown; every
  // per-sample field lives in the back, so the two sides stall independently.
  msfd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .expect_hdr_i (expect_hdr_q),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  msfd_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  msfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_o       (out_o)
  );

endmodule

// ===== rtl/msfd_front.sv =====
// Front of the frame deframer: accepts words and tracks the parse phase.
// Depends on msfd_pkg and msfd_if; feeds classified words into msfd_fifo.
module msfd_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             expect_hdr_i,
  msfd_in_if.sink          in_i,
  output logic             push_valid_o,
  input  logic             push_ready_i,
  output msfd_pkg::entry_t push_data_o
);
  import msfd_pkg::*;

  phase_e      phase_q, phase_d;
  logic [11:0] left_q, left_d;
  phase_e      cur_phase;
  logic        start;
  logic        accept;
  logic [11:0] left_eff;
  logic [11:0] left_dec;
  logic [9:0]  hdr_id;
  logic [4:0]  hdr_idx;
  logic [11:0] hdr_len;
  logic        is_trailer;

  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid;
  assign accept       = in_i.valid && push_ready_i;

  // A frame start, or any word straight after reset, restarts parsing.
  assign start     = in_i.frame_start || (phase_q == PH_IDLE);
  assign cur_phase = start ? (expect_hdr_i ? PH_RO_HDR : PH_SHDR) : phase_q;
  assign left_eff  = start ? 12'd0 : left_q;
  assign left_dec  = left_eff - 12'd1;

  assign hdr_id     = in_i.data_word[27:18];
  assign hdr_idx    = in_i.data_word[17:13];
  assign hdr_len    = in_i.data_word[11:0];
  assign is_trailer = (hdr_id == ID_TRAILER) && (hdr_idx == IDX_TRAILER);

  always_comb begin
    phase_d = cur_phase;
    left_d  = left_eff;
    case (cur_phase)
      PH_RO_HDR: phase_d = PH_RSV;
      PH_RSV:    phase_d = PH_TS_LO;
      PH_TS_LO:  phase_d = PH_TS_HI;
      PH_TS_HI:  phase_d = PH_SHDR;
      PH_SHDR: begin
        if (is_trailer) begin
          phase_d = PH_DONE;
        end else if (hdr_len != 12'd0) begin
          phase_d = PH_PAYLOAD;
          left_d  = hdr_len;
        end
      end
      PH_PAYLOAD: begin
        left_d = left_dec;
        if (left_dec == 12'd0) begin
          phase_d = PH_SHDR;
        end
      end
      default: phase_d = cur_phase;
    endcase
  end

  always_comb begin
    push_data_o.word  = in_i.data_word;
    push_data_o.start = start;
    push_data_o.kind  = KIND_IGNORE;
    push_data_o.last  = 1'b0;
    case (cur_phase)
      PH_RO_HDR: push_data_o.kind = KIND_RO_HDR;
      PH_RSV:    push_data_o.kind = KIND_RSV;
      PH_TS_LO:  push_data_o.kind = KIND_TS_LO;
      PH_TS_HI:  push_data_o.kind = KIND_TS_HI;
      PH_SHDR: begin
        if (!is_trailer) begin
          push_data_o.kind = KIND_SHDR;
          push_data_o.last = (hdr_len == 12'd0);
        end
      end
      PH_PAYLOAD: begin
        push_data_o.kind = KIND_PAYLOAD;
        push_data_o.last = (left_dec == 12'd0);
      end
      default: push_data_o.kind = KIND_IGNORE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      left_q  <= 12'd0;
    end else if (accept) begin
      phase_q <= phase_d;
      left_q  <= left_d;
    end
  end

endmodule

// ===== rtl/msfd_fifo.sv =====
// Short queue of classified words between the front and the back.
// Depends on msfd_pkg.
module msfd_fifo #(
  parameter int unsigned Depth = msfd_pkg::FIFO_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  msfd_pkg::entry_t push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output msfd_pkg::entry_t pop_data_o
);
  import msfd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CntW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

// ===== rtl/msfd_back.sv =====
// Back of the frame deframer: sample counting, header fields, result register.
// Depends on msfd_pkg and msfd_if; drains classified words from msfd_fifo.
module msfd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pop_valid_i,
  output logic             pop_ready_o,
  input  msfd_pkg::entry_t pop_data_i,
  msfd_out_if.source       out_o
);
  import msfd_pkg::*;

  logic [7:0]  count_q, count_d;
  logic [9:0]  last_id_q, last_id_d;
  logic [7:0]  interest_q, interest_d;
  logic [7:0]  contrib_q, contrib_d;
  logic [7:0]  subsys_q, subsys_d;
  logic [31:0] stamp_lo_q, stamp_lo_d;
  logic        cur_soi_q, cur_soi_d;
  logic        out_valid_q;
  result_t     res_q, res_d;

  logic [7:0]  count_b, count_inc;
  logic [9:0]  hdr_id;
  logic [4:0]  hdr_idx;
  logic        hdr_soi;
  logic        pop;
  logic [31:0] w;

  assign pop_ready_o = !out_valid_q || out_o.ready;
  assign pop         = pop_valid_i && pop_ready_o;

  assign w         = pop_data_i.word;
  assign hdr_id    = w[27:18];
  assign hdr_idx   = w[17:13];
  assign hdr_soi   = w[12];
  assign count_b   = pop_data_i.start ? 8'd0 : count_q;
  assign count_inc = (count_b == COUNT_MAX) ? count_b : count_b + 8'd1;

  always_comb begin
    // A frame start clears the per-frame state before the word is handled.
    count_d    = count_b;
    last_id_d  = last_id_q;
    interest_d = interest_q;
    contrib_d  = pop_data_i.start ? 8'd0 : contrib_q;
    subsys_d   = pop_data_i.start ? 8'd0 : subsys_q;
    stamp_lo_d = pop_data_i.start ? 32'd0 : stamp_lo_q;
    cur_soi_d  = pop_data_i.start ? 1'b0 : cur_soi_q;

    res_d                = '0;
    res_d.word_kind      = pop_data_i.kind;
    res_d.word_out       = w;

    case (pop_data_i.kind)
      KIND_RO_HDR: begin
        contrib_d = w[23:16];
        subsys_d  = w[15:8];
      end
      KIND_TS_LO: stamp_lo_d = w;
      KIND_TS_HI: res_d.stamp = {w, stamp_lo_d};
      KIND_SHDR: begin
        res_d.id_mismatch    = (count_b != 8'd0) && (last_id_q != hdr_id);
        res_d.index_mismatch = (count_b != {3'd0, hdr_idx});
        res_d.sample_index   = count_b;
        res_d.link_id        = hdr_id;
        res_d.interest_flag  = hdr_soi;
        res_d.last_of_sample = pop_data_i.last;
        last_id_d            = hdr_id;
        cur_soi_d            = hdr_soi;
        if (hdr_soi) begin
          interest_d = count_b;
        end
        if (pop_data_i.last) begin
          count_d = count_inc;
        end
      end
      KIND_PAYLOAD: begin
        res_d.sample_index   = count_b;
        res_d.link_id        = last_id_q;
        res_d.interest_flag  = cur_soi_d;
        res_d.last_of_sample = pop_data_i.last;
        if (pop_data_i.last) begin
          count_d = count_inc;
        end
      end
      default: res_d.stamp = 64'd0;
    endcase

    res_d.interest_index = interest_d;
    res_d.contributor    = contrib_d;
    res_d.subsystem      = subsys_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= 8'd0;
      last_id_q   <= 10'd0;
      interest_q  <= 8'd0;
      contrib_q   <= 8'd0;
      subsys_q    <= 8'd0;
      stamp_lo_q  <= 32'd0;
      cur_soi_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        count_q     <= count_d;
        last_id_q   <= last_id_d;
        interest_q  <= interest_d;
        contrib_q   <= contrib_d;
        subsys_q    <= subsys_d;
        stamp_lo_q  <= stamp_lo_d;
        cur_soi_q   <= cur_soi_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.word_kind      = res_q.word_kind;
  assign out_o.word_out       = res_q.word_out;
  assign out_o.sample_index   = res_q.sample_index;
  assign out_o.link_id        = res_q.link_id;
  assign out_o.interest_flag  = res_q.interest_flag;
  assign out_o.interest_index = res_q.interest_index;
  assign out_o.id_mismatch    = res_q.id_mismatch;
  assign out_o.index_mismatch = res_q.index_mismatch;
  assign out_o.last_of_sample = res_q.last_of_sample;
  assign out_o.contributor    = res_q.contributor;
  assign out_o.subsystem      = res_q.subsystem;
  assign out_o.stamp          = res_q.stamp;

endmodule

// ===== rtl/msfd_checker.sv =====
// Port-level checks of the frame deframer result stream, bound to the top level.
// Depends on msfd_pkg and multi_sample_frame_deframer_core_assert.svh.
`include "multi_sample_frame_deframer_core_assert.svh"

module msfd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  word_kind_i,
  input logic [31:0] word_out_i,
  input logic [9:0]  link_id_i,
  input logic [7:0]  sample_index_i,
  input logic        interest_flag_i,
  input logic        id_mismatch_i,
  input logic        index_mismatch_i,
  input logic        last_of_sample_i,
  input logic [63:0] stamp_i
);
  import msfd_pkg::*;

  `MSFD_ASSERT_ALWAYS(a_no_beat_in_reset, clk_i, !rst_ni |-> !out_valid_i, "result beat during reset")

  `MSFD_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(word_out_i), "stalled result beat changed")

  `MSFD_ASSERT(a_stamp_only_hi, clk_i, rst_ni, out_valid_i && (word_kind_i != KIND_TS_HI) |-> (stamp_i == 64'd0), "timestamp outside the timestamp high word")

  `MSFD_ASSERT(a_non_sample_zero, clk_i, rst_ni, out_valid_i && ((word_kind_i == KIND_RO_HDR) || (word_kind_i == KIND_IGNORE)) |-> (link_id_i == 10'd0) && (sample_index_i == 8'd0) && !interest_flag_i && !id_mismatch_i && !index_mismatch_i && !last_of_sample_i, "sample fields set on a non-sample word")

endmodule

bind multi_sample_frame_deframer_core msfd_checker u_msfd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .word_kind_i      (out_o.word_kind),
  .word_out_i       (out_o.word_out),
  .link_id_i        (out_o.link_id),
  .sample_index_i   (out_o.sample_index),
  .interest_flag_i  (out_o.interest_flag),
  .id_mismatch_i    (out_o.id_mismatch),
  .index_mismatch_i (out_o.index_mismatch),
  .last_of_sample_i (out_o.last_of_sample),
  .stamp_i          (out_o.stamp)
);

// ===== verif/tb.sv =====
// Self-checking testbench of multi_sample_frame_deframer_core: a directed table, then random frames.
// Depends on msfd_pkg, the stream interfaces in msfd_if and the RTL of the core.
`timescale 1ns / 100ps

module tb;
  import msfd_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DIR_ROWS    = 25;
  localparam int PHASE_WORDS = 420;
  // Payload length of the long sample that is run to its end in the second phase.
  localparam int LONG_LEN    = 600;
  // Register index 1 has no register behind it; writes there must be ignored.
  localparam int SPARE_REG   = 1;

  typedef enum {SHAPE_PLAIN, SHAPE_SATURATE, SHAPE_LONG} frame_shape_e;

  // One input beat as the sender drives it.
  typedef struct {
    logic [31:0] word;
    logic        start;
  } beat_t;

  // One row of the directed table. Where pinned is set, the kind and the two mismatch
  // flags are typed in here; every other field comes from the predictor.
  typedef struct {
    bit          mode;
    logic [31:0] word;
    logic        start;
    bit          pinned;
    kind_e       kind;
    logic        idm;
    logic        ixm;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  msfd_in_if  in_bus ();
  msfd_out_if out_bus ();

  multi_sample_frame_deframer_core DUT (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor state: our own copy of the parser and of the header-mode register.
  bit          hdr_mode     = 1'b0;
  phase_e      parse_st     = PH_IDLE;
  logic [11:0] words_left   = '0;
  logic [7:0]  sample_cnt   = '0;
  logic [9:0]  prev_id      = '0;
  logic [7:0]  interest_lat = '0;
  logic [7:0]  contrib_lat  = '0;
  logic [7:0]  subsys_lat   = '0;
  logic [31:0] stamp_lo_lat = '0;
  logic        soi_cur      = 1'b0;

  result_t  expected_q [$];
  beat_t    stim_q [$];
  dir_row_t dir_tab [DIR_ROWS];
  int       err_cnt = 0;
  bit       tx_burst = 1'b0;
  bit       rx_burst = 1'b0;

  // Clock and a single reset pulse at the start of the run.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Timeout guard: a hung handshake ends the run here.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("%0t: timeout after %0d cycles, %0d results outstanding", $time, CYCLE_LIMIT,
             expected_q.size());
    $display("== FAIL ==");
    $finish;
  end

  // Packs a sample header word: spare top bits, id, index, sample-of-interest bit, length.
  function automatic logic [31:0] sample_hdr(logic [3:0] top, logic [9:0] id, logic [4:0] idx,
                                             logic soi, logic [11:0] len);
    return {top, id, idx, soi, len};
  endfunction

  // Builds one input beat from a word and its frame start flag.
  function automatic beat_t mk_beat(logic [31:0] w, logic s);
    beat_t b;
    b.word  = w;
    b.start = s;
    return b;
  endfunction

  // Idle cycles before the next beat of one side. Burst stretches leave no gap.
  function automatic int next_gap(ref bit burst);
    if ($urandom_range(0, 39) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 17);
  endfunction

  // Classifies one word and advances the predicted parser state, exactly one result per word.
  function automatic result_t classify_word(logic [31:0] w, logic fs);
    result_t     r;
    logic [9:0]  id;
    logic [4:0]  idx;
    logic        soi;
    logic [11:0] len;
    r = '0;
    r.word_kind = KIND_IGNORE;
    r.word_out  = w;
    id  = w[27:18];
    idx = w[17:13];
    soi = w[12];
    len = w[11:0];
    // A flagged start, or any word straight after reset, opens a new frame. The latched
    // interest index and the previous id survive the frame boundary.
    if (fs || parse_st == PH_IDLE) begin
      sample_cnt   = '0;
      words_left   = '0;
      contrib_lat  = '0;
      subsys_lat   = '0;
      stamp_lo_lat = '0;
      soi_cur      = 1'b0;
      parse_st     = hdr_mode ? PH_RO_HDR : PH_SHDR;
    end
    case (parse_st)
      PH_RO_HDR: begin
        r.word_kind = KIND_RO_HDR;
        contrib_lat = w[23:16];
        subsys_lat  = w[15:8];
        parse_st    = PH_RSV;
      end
      PH_RSV: begin
        r.word_kind = KIND_RSV;
        parse_st    = PH_TS_LO;
      end
      PH_TS_LO: begin
        r.word_kind  = KIND_TS_LO;
        stamp_lo_lat = w;
        parse_st     = PH_TS_HI;
      end
      PH_TS_HI: begin
        r.word_kind = KIND_TS_HI;
        r.stamp     = {w, stamp_lo_lat};
        parse_st    = PH_SHDR;
      end
      PH_SHDR: begin
        if (idx == IDX_TRAILER && id == ID_TRAILER) begin
          parse_st = PH_DONE;
        end else begin
          r.word_kind      = KIND_SHDR;
          r.id_mismatch    = (sample_cnt != 0) && (prev_id != id);
          r.index_mismatch = (sample_cnt != {3'b000, idx});
          prev_id          = id;
          soi_cur          = soi;
          if (soi) interest_lat = sample_cnt;
          r.sample_index   = sample_cnt;
          r.link_id        = id;
          r.interest_flag  = soi;
          if (len == 0) begin
            r.last_of_sample = 1'b1;
            if (sample_cnt != COUNT_MAX) sample_cnt++;
          end else begin
            words_left = len;
            parse_st   = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        r.word_kind     = KIND_PAYLOAD;
        r.sample_index  = sample_cnt;
        r.link_id       = prev_id;
        r.interest_flag = soi_cur;
        words_left      = words_left - 12'd1;
        if (words_left == 0) begin
          r.last_of_sample = 1'b1;
          if (sample_cnt != COUNT_MAX) sample_cnt++;
          parse_st = PH_SHDR;
        end
      end
      default: ;
    endcase
    r.interest_index = interest_lat;
    r.contributor    = contrib_lat;
    r.subsystem      = subsys_lat;
    return r;
  endfunction

  // APB write: setup cycle, then access cycle; the register takes the value at the edge
  // where pready is seen high during access.
  task automatic write_reg(int idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(idx * 4);
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_EXPECT_HDR) hdr_mode = val[0];
  endtask

  // Drops valid and waits until every expected result beat has been checked.
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Sends one beat. The expectation is queued before valid rises, so it is always in
  // place before the result can appear. Valid stays high when the next beat has no gap.
  task automatic send_beat(beat_t b, bit pinned, kind_e k, logic idm, logic ixm);
    result_t exp;
    int      gap;
    gap = next_gap(tx_burst);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    exp = classify_word(b.word, b.start);
    if (pinned) begin
      exp.word_kind      = k;
      exp.id_mismatch    = idm;
      exp.index_mismatch = ixm;
    end
    expected_q = {expected_q, exp};
    in_bus.valid       <= 1'b1;
    in_bus.data_word   <= b.word;
    in_bus.frame_start <= b.start;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  // Builds one frame of random content into the stimulus queue. Most frames are well
  // formed; some are cut short, left open by a long length, or start without the flag.
  task automatic make_frame(bit hdr, frame_shape_e shape);
    beat_t       fr [$];
    int          nsamp;
    int          cnt;
    int          len;
    int          keep;
    logic [9:0]  id;
    logic [4:0]  idx;
    bit          cut;
    bit          open;
    cut  = ($urandom_range(0, 9) == 0);
    open = 1'b0;
    cnt  = 0;
    id   = 10'($urandom);
    if (hdr) repeat (4) fr = {fr, mk_beat($urandom, 1'b0)};
    nsamp = (shape == SHAPE_SATURATE) ? $urandom_range(256, 300) : $urandom_range(1, 8);
    for (int s = 0; s < nsamp; s++) begin
      if ($urandom_range(0, 4) == 0) id = 10'($urandom);
      idx = ($urandom_range(0, 5) == 0) ? 5'($urandom) : 5'(cnt);
      if (shape == SHAPE_SATURATE) begin
        len = 0;
      end else if (shape == SHAPE_LONG && s == 0) begin
        len = LONG_LEN;
      end else if ($urandom_range(0, 11) == 0) begin
        // Long length that the next frame start will cut off mid-payload.
        len  = $urandom_range(6, 4095);
        open = 1'b1;
      end else begin
        len = $urandom_range(0, 5);
      end
      fr = {fr, mk_beat(sample_hdr(4'($urandom), id, idx, 1'($urandom_range(0, 3) == 0),
                                   12'(len)), 1'b0)};
      if (open) begin
        repeat ($urandom_range(0, 6)) fr = {fr, mk_beat($urandom, 1'b0)};
        break;
      end
      repeat (len) fr = {fr, mk_beat($urandom, 1'b0)};
      cnt++;
    end
    if (!open && $urandom_range(0, 6) != 0)
      fr = {fr, mk_beat(sample_hdr(4'($urandom), ID_TRAILER, IDX_TRAILER, 1'($urandom),
                                   12'($urandom)), 1'b0)};
    // A few stray words after the frame; they are ignored once the trailer has passed.
    repeat ($urandom_range(0, 2)) fr = {fr, mk_beat($urandom, 1'b0)};
    fr[0].start = ($urandom_range(0, 19) != 0);
    keep = cut ? $urandom_range(1, fr.size()) : fr.size();
    for (int i = 0; i < keep; i++) stim_q = {stim_q, fr[i]};
  endtask

  // Compares one field of a result beat and reports a mismatch.
  task automatic check_field(string name, logic [63:0] exp, logic [63:0] act);
    if (exp !== act) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp, act);
      err_cnt++;
    end
  endtask

  // Result side: random stalls on ready; every accepted beat is checked against the oldest
  // expectation. Values are read right after the edge, so they are those the edge saw.
  initial begin
    result_t exp;
    int      gap;
    out_bus.ready <= 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      gap = next_gap(rx_burst);
      if (gap > 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
      if (expected_q.size() == 0) begin
        $display("%0t: result beat with no expectation pending, word %0h", $time,
                 out_bus.word_out);
        err_cnt++;
      end else begin
        exp = expected_q.pop_front();
        check_field("word_kind",      exp.word_kind,      out_bus.word_kind);
        check_field("word_out",       exp.word_out,       out_bus.word_out);
        check_field("sample_index",   exp.sample_index,   out_bus.sample_index);
        check_field("link_id",        exp.link_id,        out_bus.link_id);
        check_field("interest_flag",  exp.interest_flag,  out_bus.interest_flag);
        check_field("interest_index", exp.interest_index, out_bus.interest_index);
        check_field("id_mismatch",    exp.id_mismatch,    out_bus.id_mismatch);
        check_field("index_mismatch", exp.index_mismatch, out_bus.index_mismatch);
        check_field("last_of_sample", exp.last_of_sample, out_bus.last_of_sample);
        check_field("contributor",    exp.contributor,    out_bus.contributor);
        check_field("subsystem",      exp.subsystem,      out_bus.subsystem);
        check_field("stamp",          exp.stamp,          out_bus.stamp);
      end
    end
  end

  // Main sequence: directed table, then four random phases that alternate the header mode.
  initial begin
    beat_t b;
    bit    mode;
    int    n;
    in_bus.valid       <= 1'b0;
    in_bus.data_word   <= '0;
    in_bus.frame_start <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;

    // Directed rows. The first word after reset opens a frame without the start flag;
    // later rows cover id and index mismatches, the all-ones id that is not a trailer,
    // frames cut off mid-payload, the trailer and the words after it,
    // and the readout header with extreme contributor, subsystem and stamp values.
    dir_tab = '{
      '{1'b0, sample_hdr(4'h0, 10'd5,     5'd0,  1'b0, 12'd2),     1'b0, 1'b1, KIND_SHDR,    1'b0, 1'b0},
      '{1'b0, 32'hffff_ffff,                                      1'b0, 1'b1, KIND_PAYLOAD, 1'b0, 1'b0},
      '{1'b0, 32'h0000_0000,                                      1'b0, 1'b1, KIND_PAYLOAD, 1'b0, 1'b0},
      '{1'b0, sample_hdr(4'hf, 10'd6,     5'd1,  1'b1, 12'd0),     1'b0, 1'b1, KIND_SHDR,    1'b1, 1'b0},
      '{1'b0, sample_hdr(4'h0, 10'd6,     5'h1f, 1'b0, 12'd1),     1'b0, 1'b1, KIND_SHDR,    1'b0, 1'b1},
      '{1'b0, 32'h1234_5678,                                      1'b0, 1'b1, KIND_PAYLOAD, 1'b0, 1'b0},
      '{1'b0, sample_hdr(4'h0, 10'h3ff,   5'd3,  1'b0, 12'd3),     1'b0, 1'b1, KIND_SHDR,    1'b1, 1'b0},
      '{1'b0, 32'ha5a5_a5a5,                                      1'b0, 1'b1, KIND_PAYLOAD, 1'b0, 1'b0},
      '{1'b0, sample_hdr(4'h0, 10'd0,     5'd0,  1'b0, 12'd0),     1'b1, 1'b1, KIND_SHDR,    1'b0, 1'b0},
      '{1'b0, sample_hdr(4'h0, 10'd0,     5'd1,  1'b0, 12'hfff),   1'b0, 1'b1, KIND_SHDR,    1'b0, 1'b0},
      '{1'b0, 32'hdead_beef,                                      1'b0, 1'b0, KIND_IGNORE,  1'b0, 1'b0},
      '{1'b0, sample_hdr(4'h0, ID_TRAILER, IDX_TRAILER, 1'b1, 12'hfff), 1'b1, 1'b1, KIND_IGNORE, 1'b0, 1'b0},
      '{1'b0, 32'hffff_ffff,                                      1'b0, 1'b1, KIND_IGNORE,  1'b0, 1'b0},
      '{1'b0, sample_hdr(4'h0, 10'd4,     5'd0,  1'b0, 12'd0),     1'b0, 1'b1, KIND_IGNORE,  1'b0, 1'b0},
      '{1'b1, 32'hffff_ffff,                                      1'b1, 1'b1, KIND_RO_HDR,  1'b0, 1'b0},
      '{1'b1, 32'h0000_0000,                                      1'b0, 1'b1, KIND_RSV,     1'b0, 1'b0},
      '{1'b1, 32'hffff_ffff,                                      1'b0, 1'b1, KIND_TS_LO,   1'b0, 1'b0},
      '{1'b1, 32'h8000_0001,                                      1'b0, 1'b1, KIND_TS_HI,   1'b0, 1'b0},
      '{1'b1, sample_hdr(4'h0, 10'd2,     5'd0,  1'b1, 12'd1),     1'b0, 1'b1, KIND_SHDR,    1'b0, 1'b0},
      '{1'b1, 32'h00ab_cd00,                                      1'b1, 1'b1, KIND_RO_HDR,  1'b0, 1'b0},
      '{1'b1, 32'hffff_ffff,                                      1'b0, 1'b1, KIND_RSV,     1'b0, 1'b0},
      '{1'b1, 32'h0000_0000,                                      1'b0, 1'b1, KIND_TS_LO,   1'b0, 1'b0},
      '{1'b1, 32'h0000_0000,                                      1'b0, 1'b1, KIND_TS_HI,   1'b0, 1'b0},
      '{1'b1, sample_hdr(4'h0, ID_TRAILER, IDX_TRAILER, 1'b0, 12'd0), 1'b0, 1'b1, KIND_IGNORE, 1'b0, 1'b0},
      '{1'b1, 32'h7fff_ffff,                                      1'b0, 1'b1, KIND_IGNORE,  1'b0, 1'b0}
    };

    @(posedge rst_n);
    @(posedge clk);
    // A write to the unused register index must leave the header mode at its reset value.
    write_reg(SPARE_REG, '1);

    for (int i = 0; i < DIR_ROWS; i++) begin
      // The header mode is only changed while nothing is in flight.
      if (dir_tab[i].mode != hdr_mode) begin
        wait_drained();
        write_reg(REG_EXPECT_HDR, {31'($urandom), dir_tab[i].mode});
      end
      b = '{dir_tab[i].word, dir_tab[i].start};
      send_beat(b, dir_tab[i].pinned, dir_tab[i].kind, dir_tab[i].idm, dir_tab[i].ixm);
    end

    // Random phases. The first takes a frame long enough to saturate the sample count, the
    // second a sample with a long payload run to its end.
    for (int p = 0; p < 4; p++) begin
      mode = p[0];
      wait_drained();
      write_reg(REG_EXPECT_HDR, {31'($urandom), mode});
      if (p == 0) make_frame(mode, SHAPE_SATURATE);
      if (p == 1) make_frame(mode, SHAPE_LONG);
      while (stim_q.size() < PHASE_WORDS) begin
        if ($urandom_range(0, 99) < 6) stim_q = {stim_q, mk_beat($urandom, 1'($urandom))};
        else make_frame(mode, SHAPE_PLAIN);
      end
      n = 0;
      while (stim_q.size() != 0) begin
        // Halfway through each phase the sender holds off until the output has caught up.
        if (n == PHASE_WORDS / 2) wait_drained();
        send_beat(stim_q.pop_front(), 1'b0, KIND_IGNORE, 1'b0, 1'b0);
        n++;
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
